// File: src/signed_int_to_decimal_ascii_core_defines.svh
// Assertion macros shared by the core's modules.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SITDA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SITDA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/sitda_pkg.sv
package sitda_pkg;

    localparam int WORD_BITS  = 32;
    // magnitude bits shifted into the BCD register per converter cycle
    localparam int STEP_BITS  = 4;
    localparam int STEPS      = (WORD_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS   = STEPS * STEP_BITS;
    // decimal digits of 2^(WORD_BITS-1), rounded up: log10(2) ~ 0.30103
    localparam int DIGITS     = (WORD_BITS * 30103) / 100000 + 1;
    localparam int DIG_IDX_W  = $clog2(DIGITS);
    localparam int STEP_CNT_W = $clog2(STEPS);
    // queue depth, a power of two
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef logic [DIGITS-1:0][3:0] digits_t;

    typedef struct packed {
        logic                neg;
        logic [PAD_BITS-1:0] mag;
    } entry_t;

    typedef struct packed {
        logic                 neg;
        logic [DIG_IDX_W-1:0] top;
        digits_t              digits;
    } conv_result_t;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_RUN,
        CV_DONE
    } conv_state_t;

endpackage

// File: src/sitda_front.sv
module sitda_front (
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [sitda_pkg::WORD_BITS-1:0] value,
    output logic                                   push,
    output sitda_pkg::entry_t                      entry,
    input  logic                                   full
);
    import sitda_pkg::*;

    logic [WORD_BITS-1:0] raw;
    logic [WORD_BITS-1:0] mag_w;

    // the most negative value negates to itself, which reads right as unsigned
    assign raw      = value;
    assign mag_w    = raw[WORD_BITS-1] ? (~raw + WORD_BITS'(1)) : raw;
    assign entry    = '{neg: raw[WORD_BITS-1], mag: PAD_BITS'(mag_w)};
    assign in_stall = full;
    assign push     = in_valid && !full;

endmodule

// File: src/sitda_queue.sv
`include "signed_int_to_decimal_ascii_core_defines.svh"

module sitda_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sitda_pkg::entry_t push_data,
    output logic              full,
    output logic              q_valid,
    output sitda_pkg::entry_t q_data,
    input  logic              pop
);
    import sitda_pkg::*;

    entry_t               entries_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 do_pop;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entries_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    `SITDA_ASSERT_IMP(a_queue_count, 1'b1, count_reg <= Q_CNT_W'(Q_DEPTH), "queue overfilled")

endmodule

// File: src/sitda_conv.sv
`include "signed_int_to_decimal_ascii_core_defines.svh"

module sitda_conv (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  sitda_pkg::entry_t       q_data,
    output logic                    pop,
    output logic                    res_valid,
    output sitda_pkg::conv_result_t res,
    input  logic                    res_take
);
    import sitda_pkg::*;

    conv_state_t             state_reg;
    conv_state_t             state_next;
    logic [STEP_CNT_W-1:0]   cnt_reg;
    logic [STEP_CNT_W-1:0]   cnt_next;
    logic [PAD_BITS-1:0]     mag_reg;
    logic [PAD_BITS-1:0]     mag_next;
    digits_t                 bcd_reg;
    digits_t                 bcd_next;
    logic                    neg_reg;
    logic                    neg_next;
    logic [DIG_IDX_W-1:0]    top;

    // one double-dabble step: bump digits of five or more by three, shift in a bit
    function automatic digits_t dd_step(input digits_t b, input logic bit_in);
        digits_t adj;
        for (int i = 0; i < DIGITS; i++)
        begin
            adj[i] = (b[i] >= 4'd5) ? b[i] + 4'd3 : b[i];
        end
        // drop the bit shifted out of the top digit
        return digits_t'({adj, bit_in});
    endfunction

    always_comb
    begin
        logic                load;
        digits_t             b;
        logic [PAD_BITS-1:0] m;
        load       = 1'b0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        b          = bcd_reg;
        m          = mag_reg;
        case (state_reg)
            CV_IDLE:
            begin
                load = q_valid;
            end
            CV_RUN:
            begin
                for (int s = 0; s < STEP_BITS; s++)
                begin
                    b = dd_step(b, m[PAD_BITS-1]);
                    m = m << 1;
                end
                bcd_next = b;
                mag_next = m;
                cnt_next = cnt_reg + STEP_CNT_W'(1);
                if (cnt_reg == STEP_CNT_W'(STEPS - 1))
                begin
                    state_next = CV_DONE;
                end
            end
            CV_DONE:
            begin
                if (res_take)
                begin
                    load       = q_valid;
                    state_next = CV_IDLE;
                end
            end
            default:
            begin
                state_next = CV_IDLE;
            end
        endcase
        if (load)
        begin
            mag_next   = q_data.mag;
            neg_next   = q_data.neg;
            bcd_next   = '0;
            cnt_next   = '0;
            state_next = CV_RUN;
        end
        pop = load;
    end

    // highest nonzero digit; zero leaves the single digit at index 0
    always_comb
    begin
        top = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                top = DIG_IDX_W'(i);
            end
        end
    end

    assign res_valid = (state_reg == CV_DONE);
    assign res       = '{neg: neg_reg, top: top, digits: bcd_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    `SITDA_ASSERT_NXT(a_run_ends, state_reg == CV_RUN, state_reg != CV_IDLE, "conversion dropped")
    `SITDA_ASSERT_IMP(a_top_digit, res_valid, (top == '0) || (bcd_reg[top] != 4'd0), "bad top digit")

endmodule

// File: src/sitda_emit.sv
`include "signed_int_to_decimal_ascii_core_defines.svh"

module sitda_emit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    res_valid,
    input  sitda_pkg::conv_result_t res,
    output logic                    res_take,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [7:0]              char_code,
    output logic                    last
);
    import sitda_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 neg_pend_reg;
    logic                 neg_pend_next;
    logic [DIG_IDX_W-1:0] idx_reg;
    logic [DIG_IDX_W-1:0] idx_next;
    digits_t              dig_reg;
    digits_t              dig_next;
    logic                 ov_reg;
    logic                 ov_next;
    logic [7:0]           char_reg;
    logic [7:0]           char_next;
    logic                 last_reg;
    logic                 last_next;
    logic                 adv;
    logic                 finishing;

    assign adv       = !ov_reg || !out_stall;
    assign finishing = adv && busy_reg && !neg_pend_reg && (idx_reg == '0);
    // load the next string in the cycle the current one sends its final digit
    assign res_take  = res_valid && (!busy_reg || finishing);

    always_comb
    begin
        busy_next     = busy_reg;
        neg_pend_next = neg_pend_reg;
        idx_next      = idx_reg;
        dig_next      = dig_reg;
        ov_next       = ov_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        if (adv)
        begin
            ov_next = busy_reg;
            if (busy_reg)
            begin
                if (neg_pend_reg)
                begin
                    char_next     = CHAR_MINUS;
                    last_next     = 1'b0;
                    neg_pend_next = 1'b0;
                end
                else
                begin
                    char_next = CHAR_ZERO + {4'd0, dig_reg[idx_reg]};
                    last_next = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg - DIG_IDX_W'(1);
                    end
                end
            end
        end
        if (res_take)
        begin
            busy_next     = 1'b1;
            neg_pend_next = res.neg;
            idx_next      = res.top;
            dig_next      = res.digits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            neg_pend_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            neg_pend_reg <= neg_pend_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        dig_reg  <= dig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = ov_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

    `SITDA_ASSERT_IMP(a_minus_not_last, ov_reg && (char_reg == CHAR_MINUS), !last_reg, "sign ends string")
    `SITDA_ASSERT_NXT(a_take_loads, res_take, busy_reg, "string not loaded")

endmodule

// File: src/signed_int_to_decimal_ascii_core.sv
// Signed integer to decimal ASCII converter.
// Input channel: in_valid / in_stall carry one signed value per beat.
// Output channel: out_valid / out_stall carry one character per beat,
// char_code is '-' or a digit, most significant first, last marks the final
// character of each value's string. No leading zeros; zero gives "0".
// A front stage splits sign and magnitude into a two-entry queue; the
// converter turns a magnitude into BCD four bits per cycle (double dabble);
// the emitter then sends one character per cycle while out_stall is low,
// from a registered output. The queue and converter work on the next
// value while the emitter sends the current string; a value has 1 to 11
// characters, and when the next result is ready its string follows the
// final character of the previous one with no gap.
// Reset clears the queue, converter and output; nothing is kept between
// values. While out_stall is high the output beat holds, and the queue
// fills and raises in_stall once the converter and emitter are both busy.
module signed_int_to_decimal_ascii_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [sitda_pkg::WORD_BITS-1:0] value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [7:0]                             char_code,
    output logic                                   last
);
    import sitda_pkg::*;

    logic         push;
    entry_t       entry;
    logic         full;
    logic         q_valid;
    entry_t       q_data;
    logic         pop;
    logic         res_valid;
    conv_result_t res;
    logic         res_take;

    sitda_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .value    (value),
        .push     (push),
        .entry    (entry),
        .full     (full)
    );

    sitda_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .full      (full),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop)
    );

    sitda_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    sitda_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last      (last)
    );

endmodule
